// ===== hw/rtl/wav_header_parser_macros.svh =====
`ifndef WAV_HEADER_PARSER_MACROS_SVH
`define WAV_HEADER_PARSER_MACROS_SVH

// Checks sampled on clk, off while rst_n is low.
`define WHP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define WHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/whp_pkg.sv =====
package whp_pkg;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int FORMAT_W = 16;
  localparam int RATE_W   = 32;
  localparam int SIZE_W   = 32;
  localparam int DUR_W    = 48;
  localparam int FRAC_W   = DUR_W - SIZE_W;

  localparam int DIV_STEPS = DUR_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [SIZE_W-1:0]   FMT_BASE_SIZE = 32'd16;
  localparam logic [FORMAT_W-1:0] FORMAT_PCM    = 16'd1;
  localparam logic [SIZE_W-1:0]   MID_SKIP      = 32'd6;
  localparam logic [SIZE_W-1:0]   TAIL_SKIP     = 32'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_NO_RIFF = 3'd1,
    ST_NO_WAVE = 3'd2,
    ST_NO_FMT  = 3'd3,
    ST_NO_FACT = 3'd4,
    ST_NO_DATA = 3'd5,
    ST_TRUNC   = 3'd6
  } whp_status_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RIFF     = 4'd1,
    PH_WAVE     = 4'd2,
    PH_FMT      = 4'd3,
    PH_FSIZE    = 4'd4,
    PH_FORMAT   = 4'd5,
    PH_MID      = 4'd6,
    PH_RATE     = 4'd7,
    PH_TAIL     = 4'd8,
    PH_EXTLEN   = 4'd9,
    PH_EXTSKIP  = 4'd10,
    PH_FACT     = 4'd11,
    PH_FACTSIZE = 4'd12,
    PH_FACTSKIP = 4'd13,
    PH_DATA     = 4'd14,
    PH_DSIZE    = 4'd15
  } whp_phase_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_DIV  = 2'd1,
    B_OUT  = 2'd2
  } whp_bstate_t;

  typedef struct packed {
    whp_status_t         status;
    logic [FORMAT_W-1:0] format_code;
    logic [RATE_W-1:0]   byte_rate;
    logic [SIZE_W-1:0]   data_size;
  } whp_job_t;

endpackage

// ===== hw/rtl/whp_if.sv =====
interface whp_in_if import whp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface whp_out_if import whp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FORMAT_W-1:0] format_code;
  logic [RATE_W-1:0]   byte_rate;
  logic [SIZE_W-1:0]   data_size;
  logic [DUR_W-1:0]    duration_q16;

  modport source (output valid, output status, output format_code, output byte_rate,
                  output data_size, output duration_q16, input ready);
  modport sink   (input valid, input status, input format_code, input byte_rate,
                  input data_size, input duration_q16, output ready);
endinterface

// ===== hw/rtl/wav_header_parser.sv =====
// Input: one byte word per cycle; ready drops only while the result queue is full.
// Flow: the byte that ends a parse pushes its result word into the queue in that same cycle;
// the back end pops it and shows it in B_OUT, a good header with a nonzero rate first passing
// the 48-step bit-serial duration divider. Queue of QUEUE_DEPTH; back end takes one at a time.
// Reset: synchronous active-low rst_n idles the parser until a first-byte word, empties the queue.
module wav_header_parser import whp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  whp_in_if.sink    in_ch,
  whp_out_if.source out_ch
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  whp_job_t push_job, pop_job;

  whp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (push_valid),
    .job       (push_job),
    .job_ready (push_ready)
  );

  whp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  whp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_ch    (out_ch)
  );

endmodule

// ===== hw/rtl/whp_front.sv =====
module whp_front import whp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  whp_in_if.sink     in_ch,
  output logic       job_valid,
  output whp_job_t   job,
  input  logic       job_ready
);

  whp_phase_t          phase_r, phase_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]   skip_r, skip_nxt;
  logic [31:0]         shift_r, shift_nxt;
  logic                fmt_ext_r, fmt_ext_nxt;
  logic [FORMAT_W-1:0] format_r, format_nxt;
  logic [RATE_W-1:0]   rate_r, rate_nxt;

  logic              accept;
  whp_phase_t        ph_c;
  logic [1:0]        cnt_c;
  logic [SIZE_W-1:0] skip_c, skip_dec, skip_new;
  logic [31:0]       word_c;
  logic              skip_end, last4, last2;
  whp_phase_t        ext_next, adv;
  logic              take_en, take_two, err, ok_done, emit;
  logic              load_fsz, load_fmt, load_rate;
  whp_status_t       err_code, status_c;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = job_ready;

  assign ph_c    = in_ch.first_byte ? PH_RIFF : phase_r;
  assign cnt_c   = in_ch.first_byte ? 2'd0 : cnt_r;
  assign skip_c  = in_ch.first_byte ? '0 : skip_r;

  always_comb begin
    unique case (cnt_c)
      2'd0:    word_c = {24'd0, in_ch.data_byte};
      2'd1:    word_c = {16'd0, in_ch.data_byte, shift_r[7:0]};
      2'd2:    word_c = {8'd0, in_ch.data_byte, shift_r[15:0]};
      default: word_c = {in_ch.data_byte, shift_r[23:0]};
    endcase
  end

  assign last4    = (cnt_c == 2'd3);
  assign last2    = (cnt_c == 2'd1);
  assign skip_dec = (skip_c == '0) ? '0 : skip_c - SIZE_W'(1);
  assign skip_end = (skip_dec == '0);
  assign ext_next = (format_r != FORMAT_PCM) ? PH_FACT : PH_DATA;

  always_comb begin
    adv       = ph_c;
    take_en   = 1'b0;
    take_two  = 1'b0;
    err       = 1'b0;
    err_code  = ST_TRUNC;
    ok_done   = 1'b0;
    skip_new  = skip_c;
    load_fsz  = 1'b0;
    load_fmt  = 1'b0;
    load_rate = 1'b0;
    unique case (ph_c)
      PH_IDLE: begin
      end
      PH_RIFF: begin
        take_en  = !skip_c[2];
        err      = take_en && last4 && (word_c != TAG_RIFF);
        err_code = ST_NO_RIFF;
        skip_new = skip_c + SIZE_W'(1);
        if (skip_c[2:0] == 3'd7) begin
          skip_new = '0;
          adv      = PH_WAVE;
        end
      end
      PH_WAVE: begin
        take_en  = 1'b1;
        err_code = ST_NO_WAVE;
        if (last4) begin
          if (word_c != TAG_WAVE) err = 1'b1;
          else adv = PH_FMT;
        end
      end
      PH_FMT: begin
        take_en  = 1'b1;
        err_code = ST_NO_FMT;
        if (last4) begin
          if (word_c != TAG_FMT) err = 1'b1;
          else adv = PH_FSIZE;
        end
      end
      PH_FSIZE: begin
        take_en = 1'b1;
        if (last4) begin
          load_fsz = 1'b1;
          adv      = PH_FORMAT;
        end
      end
      PH_FORMAT: begin
        take_en  = 1'b1;
        take_two = 1'b1;
        if (last2) begin
          load_fmt = 1'b1;
          skip_new = MID_SKIP;
          adv      = PH_MID;
        end
      end
      PH_MID: begin
        skip_new = skip_dec;
        if (skip_end) adv = PH_RATE;
      end
      PH_RATE: begin
        take_en = 1'b1;
        if (last4) begin
          load_rate = 1'b1;
          skip_new  = TAIL_SKIP;
          adv       = PH_TAIL;
        end
      end
      PH_TAIL: begin
        skip_new = skip_dec;
        if (skip_end) adv = fmt_ext_r ? PH_EXTLEN : ext_next;
      end
      PH_EXTLEN: begin
        take_en  = 1'b1;
        take_two = 1'b1;
        if (last2) begin
          skip_new = {16'd0, word_c[15:0]};
          adv      = (word_c[15:0] == 16'd0) ? ext_next : PH_EXTSKIP;
        end
      end
      PH_EXTSKIP: begin
        skip_new = skip_dec;
        if (skip_end) adv = ext_next;
      end
      PH_FACT: begin
        take_en  = 1'b1;
        err_code = ST_NO_FACT;
        if (last4) begin
          if (word_c != TAG_FACT) err = 1'b1;
          else adv = PH_FACTSIZE;
        end
      end
      PH_FACTSIZE: begin
        take_en = 1'b1;
        if (last4) begin
          skip_new = word_c;
          adv      = (word_c == '0) ? PH_DATA : PH_FACTSKIP;
        end
      end
      PH_FACTSKIP: begin
        skip_new = skip_dec;
        if (skip_end) adv = PH_DATA;
      end
      PH_DATA: begin
        take_en  = 1'b1;
        err_code = ST_NO_DATA;
        if (last4) begin
          if (word_c != TAG_DATA) err = 1'b1;
          else adv = PH_DSIZE;
        end
      end
      PH_DSIZE: begin
        take_en = 1'b1;
        ok_done = last4;
      end
      default: begin
      end
    endcase
  end

  assign emit = err || ok_done || ((ph_c != PH_IDLE) && in_ch.last_byte);

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      phase_nxt = emit ? PH_IDLE : adv;
    end
  end

  always_comb begin
    priority if (err) status_c = err_code;
    else if (ok_done) status_c = ST_OK;
    else status_c = ST_TRUNC;

    job_valid        = accept && emit;
    job.status       = status_c;
    job.format_code  = ok_done ? format_r : '0;
    job.byte_rate    = ok_done ? rate_r : '0;
    job.data_size    = ok_done ? word_c : '0;

    cnt_nxt     = cnt_r;
    skip_nxt    = skip_r;
    shift_nxt   = shift_r;
    fmt_ext_nxt = fmt_ext_r;
    format_nxt  = format_r;
    rate_nxt    = rate_r;
    if (accept) begin
      cnt_nxt  = cnt_c;
      skip_nxt = skip_new;
      if (take_en) begin
        shift_nxt = word_c;
        cnt_nxt   = (take_two ? last2 : last4) ? 2'd0 : cnt_c + 2'd1;
      end
      if (load_fsz)  fmt_ext_nxt = (word_c > FMT_BASE_SIZE);
      if (load_fmt)  format_nxt  = word_c[FORMAT_W-1:0];
      if (load_rate) rate_nxt    = word_c;
      if (emit) begin
        cnt_nxt  = 2'd0;
        skip_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 2'd0;
      skip_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      skip_r  <= skip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r   <= shift_nxt;
    fmt_ext_r <= fmt_ext_nxt;
    format_r  <= format_nxt;
    rate_r    <= rate_nxt;
  end

endmodule

// ===== hw/rtl/whp_queue.sv =====
module whp_queue import whp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  whp_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output whp_job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  whp_job_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    priority if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
    else count_nxt = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

// ===== hw/rtl/whp_back.sv =====
`include "wav_header_parser_macros.svh"

module whp_back import whp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  whp_job_t pop_job,
  whp_out_if.source out_ch
);

  whp_bstate_t       state_r, state_nxt;
  whp_job_t          job_r;
  logic [DUR_W-1:0]  quo_r;
  logic [RATE_W-1:0] rem_r;
  logic [STEP_W-1:0] step_r;

  logic              pop_ok, pop_div, ge;
  logic [RATE_W:0]   rem_sh;
  logic [RATE_W+1:0] diff;

  assign pop_ok  = (pop_job.status == ST_OK);
  assign pop_div = pop_ok && (pop_job.byte_rate != '0);
  assign rem_sh  = {rem_r, quo_r[DUR_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, job_r.byte_rate};
  assign ge      = !diff[RATE_W+1];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:  if (pop_valid) state_nxt = pop_div ? B_DIV : B_OUT;
      B_DIV:   if (step_r == '0) state_nxt = B_OUT;
      B_OUT:   if (out_ch.ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready           = (state_r == B_IDLE);
    out_ch.valid        = (state_r == B_OUT);
    out_ch.status       = job_r.status;
    out_ch.format_code  = job_r.format_code;
    out_ch.byte_rate    = job_r.byte_rate;
    out_ch.data_size    = job_r.data_size;
    out_ch.duration_q16 = quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_IDLE && pop_valid) begin
      job_r  <= pop_job;
      rem_r  <= '0;
      step_r <= STEP_W'(DIV_STEPS - 1);
      if (pop_div) quo_r <= {pop_job.data_size, {FRAC_W{1'b0}}};
      else if (pop_ok) quo_r <= '1;
      else quo_r <= '0;
    end else if (state_r == B_DIV) begin
      rem_r  <= ge ? diff[RATE_W-1:0] : rem_sh[RATE_W-1:0];
      quo_r  <= {quo_r[DUR_W-2:0], ge};
      step_r <= step_r - STEP_W'(1);
    end
  end

  `WHP_ASSERT_IMPL(a_div_job_ok, state_r == B_DIV, job_r.status == ST_OK && job_r.byte_rate != '0, "divide started on a job without a valid rate")
  `WHP_ASSERT_NEXT(a_div_runs, state_r == B_DIV && step_r != '0, state_r == B_DIV, "divide left before its last step")
  `WHP_ASSERT_IMPL(a_err_zero, state_r == B_OUT && job_r.status != ST_OK, quo_r == '0 && job_r.byte_rate == '0, "error word carries non-zero fields")
  `WHP_ASSERT_IMPL(a_rate_zero_sat, state_r == B_OUT && job_r.status == ST_OK && job_r.byte_rate == '0, &quo_r, "zero rate duration not saturated")

endmodule
